[rtl/zsbf_pkg.sv]
// ----------------------------------------------------------------------------
// zsbf_pkg
// shared types, constants and helpers of the zlib stored block framer
// ----------------------------------------------------------------------------
`default_nettype none

package zsbf_pkg;

  localparam int LenBits   = 32;
  localparam int ByteW     = 8;
  localparam int CfgW      = 32;
  localparam int MaxStored = 65535;
  localparam int AdlerMod  = 65521;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [ByteW-1:0] ZlibCmf = 8'h78;
  localparam logic [ByteW-1:0] ZlibFlg = 8'h01;

  // one accepted byte, classified for the back end
  typedef struct packed {
    logic             hdr;
    logic             blk;
    logic             fin;
    logic [15:0]      run;
    logic [ByteW-1:0] data;
    logic             ends;
    logic [31:0]      adler;
  } cmd_t;

  typedef enum logic [3:0] {
    POS_CMF,
    POS_FLG,
    POS_FIN,
    POS_LEN_LO,
    POS_LEN_HI,
    POS_NLEN_LO,
    POS_NLEN_HI,
    POS_DATA,
    POS_ADL3,
    POS_ADL2,
    POS_ADL1,
    POS_ADL0
  } pos_e;

  function automatic pos_e first_pos(cmd_t c);
    pos_e p;
    if (c.hdr) begin
      p = POS_CMF;
    end else if (c.blk) begin
      p = POS_FIN;
    end else begin
      p = POS_DATA;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/zlib_stored_block_framer.sv]
// ----------------------------------------------------------------------------
// zlib_stored_block_framer
// wraps a byte stream of known length in a zlib stream of stored blocks
// ----------------------------------------------------------------------------
// usage
//   cfg channel: write total_length (bytes per stream) while idle, always ready
//   s_axis: raw data bytes, one per request
//   m_axis: zlib bytes; tlast marks the final adler-32 byte of a stream
// path of an accepted request, with the block idle
//   request queue, current request register, output register
// throughput
//   one output byte per cycle while m_axis_tready is high and requests are
//   queued, set by the back end sequencer; a request gives its data byte,
//   after two stream header bytes and five block header bytes when due and
//   before four checksum bytes at stream end, at most twelve per request
// reset
//   total_length returns to 1, sums and counters restart, the queue empties
// stall
//   when m_axis_tready is low a valid output byte holds in its register;
//   the front keeps taking bytes until the four-entry request queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module zlib_stored_block_framer
  import zsbf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgW-1:0]   cfg_data_i,       // total_length
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [ByteW-1:0]  s_axis_tdata_i,   // data_byte
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [ByteW-1:0]       m_axis_tdata_o,   // out_byte
  output logic                   m_axis_tlast_o    // out_last
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  zsbf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  zsbf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  zsbf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (pop_cmd),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[rtl/zsbf_front.sv]
// ----------------------------------------------------------------------------
// zsbf_front
// accepts data bytes, tracks stream and block position, keeps adler-32 sums
// ----------------------------------------------------------------------------
`default_nettype none

module zsbf_front
  import zsbf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgW-1:0]   cfg_data_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [ByteW-1:0]  s_axis_tdata_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  logic [LenBits-1:0] total_q, total_d;
  logic [LenBits-1:0] bytes_seen_q, bytes_seen_d;
  logic [15:0]        block_left_q, block_left_d;
  logic [15:0]        sum_low_q, sum_low_d;
  logic [15:0]        sum_high_q, sum_high_d;

  logic [LenBits-1:0] total;
  logic [LenBits-1:0] remaining;
  logic               fin;
  logic [15:0]        run;
  logic [16:0]        low_sum;
  logic [15:0]        low_new;
  logic [17:0]        high_sum;
  logic [15:0]        high_new;
  logic               ends;
  logic               accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  assign push_o          = accept;

  always_comb begin
    total     = (total_q == '0) ? LenBits'(1) : total_q;
    remaining = (total > bytes_seen_q) ? (total - bytes_seen_q) : LenBits'(1);
    fin       = (remaining <= LenBits'(MaxStored));
    run       = fin ? remaining[15:0] : 16'(MaxStored);

    low_sum = {1'b0, sum_low_q} + 17'(s_axis_tdata_i);
    low_new = (low_sum >= 17'(AdlerMod)) ? 16'(low_sum - 17'(AdlerMod)) : low_sum[15:0];

    // high + low + byte stays below three times the modulus
    high_sum = 18'(sum_high_q) + 18'(sum_low_q) + 18'(s_axis_tdata_i);
    if (high_sum >= 18'(2 * AdlerMod)) begin
      high_new = 16'(high_sum - 18'(2 * AdlerMod));
    end else if (high_sum >= 18'(AdlerMod)) begin
      high_new = 16'(high_sum - 18'(AdlerMod));
    end else begin
      high_new = high_sum[15:0];
    end

    ends = ({1'b0, bytes_seen_q} + (LenBits+1)'(1)) >= {1'b0, total};

    cmd_o.hdr   = (bytes_seen_q == '0);
    cmd_o.blk   = (block_left_q == '0);
    cmd_o.fin   = fin;
    cmd_o.run   = run;
    cmd_o.data  = s_axis_tdata_i;
    cmd_o.ends  = ends;
    cmd_o.adler = {high_new, low_new};

    total_d      = cfg_valid_i ? LenBits'(cfg_data_i) : total_q;
    bytes_seen_d = bytes_seen_q;
    block_left_d = block_left_q;
    sum_low_d    = sum_low_q;
    sum_high_d   = sum_high_q;
    if (accept) begin
      if (ends) begin
        bytes_seen_d = '0;
        block_left_d = '0;
        sum_low_d    = 16'd1;
        sum_high_d   = '0;
      end else begin
        bytes_seen_d = bytes_seen_q + LenBits'(1);
        block_left_d = (cmd_o.blk ? run : block_left_q) - 16'd1;
        sum_low_d    = low_new;
        sum_high_d   = high_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= LenBits'(1);
      bytes_seen_q <= '0;
      block_left_q <= '0;
      sum_low_q    <= 16'd1;
      sum_high_q   <= '0;
    end else begin
      total_q      <= total_d;
      bytes_seen_q <= bytes_seen_d;
      block_left_q <= block_left_d;
      sum_low_q    <= sum_low_d;
      sum_high_q   <= sum_high_d;
    end
  end

  // a fresh stream always opens a fresh block
  a_hdr_opens_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_seen_q == '0 |-> block_left_q == '0)
    else $error("stream start without pending block header");

endmodule

`default_nettype wire

[rtl/zsbf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// zsbf_cmd_fifo
// short request queue between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module zsbf_cmd_fifo
  import zsbf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      empty_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (FifoAw+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (FifoAw+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FifoAw+1)'(FifoDepth))
    else $error("request queue over depth");

  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + (FifoAw+1)'(1))
    else $error("request queue count lost a push");

endmodule

`default_nettype wire

[rtl/zsbf_back.sv]
// ----------------------------------------------------------------------------
// zsbf_back
// expands each request into its data byte, after any header bytes due and
// before the checksum bytes at stream end
`default_nettype none

module zsbf_back
  import zsbf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [ByteW-1:0]       m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  cmd_t             cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  pos_e             pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic             advance;
  logic             at_end;
  logic             take;
  logic [ByteW-1:0] cur_byte;
  pos_e             next_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= POS_DATA;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    cur_byte = cur_q.data;
    next_pos = pos_q;
    unique case (pos_q)
      POS_CMF: begin
        cur_byte = ZlibCmf;
        next_pos = POS_FLG;
      end
      POS_FLG: begin
        cur_byte = ZlibFlg;
        next_pos = cur_q.blk ? POS_FIN : POS_DATA;
      end
      POS_FIN: begin
        cur_byte = {7'b0, cur_q.fin};
        next_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        cur_byte = cur_q.run[7:0];
        next_pos = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        cur_byte = cur_q.run[15:8];
        next_pos = POS_NLEN_LO;
      end
      POS_NLEN_LO: begin
        cur_byte = ~cur_q.run[7:0];
        next_pos = POS_NLEN_HI;
      end
      POS_NLEN_HI: begin
        cur_byte = ~cur_q.run[15:8];
        next_pos = POS_DATA;
      end
      POS_DATA: begin
        cur_byte = cur_q.data;
        next_pos = POS_ADL3;
      end
      POS_ADL3: begin
        cur_byte = cur_q.adler[31:24];
        next_pos = POS_ADL2;
      end
      POS_ADL2: begin
        cur_byte = cur_q.adler[23:16];
        next_pos = POS_ADL1;
      end
      POS_ADL1: begin
        cur_byte = cur_q.adler[15:8];
        next_pos = POS_ADL0;
      end
      POS_ADL0: begin
        cur_byte = cur_q.adler[7:0];
        next_pos = POS_ADL0;
      end
      default: begin
        cur_byte = cur_q.data;
        next_pos = POS_DATA;
      end
    endcase

    advance = cur_valid_q && (!out_valid_q || m_axis_tready_i);
    at_end  = ((pos_q == POS_DATA) && !cur_q.ends) || (pos_q == POS_ADL0);
    take    = !cur_valid_q || (advance && at_end);

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    pos_d       = pos_q;
    pop_o       = 1'b0;
    if (take) begin
      pop_o       = !empty_i;
      cur_valid_d = !empty_i;
      cur_d       = cmd_i;
      pos_d       = first_pos(cmd_i);
    end else if (advance) begin
      pos_d = next_pos;
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = cur_byte;
      out_last_d  = (pos_q == POS_ADL0);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_last_on_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pos_q == POS_ADL0 |=> out_valid_q && out_last_q)
    else $error("final checksum byte not marked last");

endmodule

`default_nettype wire
